// File: src/ord_pkg.sv
// Package for the opcode record decoder.
// Holds the word types, parse phase and event codes, limits and the tick scaling function.
// No dependencies.
package ord_pkg;

    // Limits on kept sets.
    localparam logic [7:0] MAX_SET_IDS = 8'd48;
    localparam logic [3:0] MAX_SETS    = 4'd8;

    // Result queue depth and pointer widths.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Opcode byte values.
    localparam logic [7:0] OP_END  = 8'd0;
    localparam logic [7:0] OP_LOOP = 8'd1;
    localparam logic [7:0] OP_SET  = 8'd2;
    localparam logic [7:0] OP_FIN  = 8'd3;
    localparam logic [7:0] OP_FOUT = 8'd4;

    typedef enum logic [3:0] {
        PH_OPCODE = 4'd0,
        PH_LOOP_N = 4'd1,
        PH_LOOP_H = 4'd2,
        PH_LOOP_L = 4'd3,
        PH_MIN_H  = 4'd4,
        PH_MIN_L  = 4'd5,
        PH_MAX_H  = 4'd6,
        PH_MAX_L  = 4'd7,
        PH_SET_N  = 4'd8,
        PH_SID_H  = 4'd9,
        PH_SID_L  = 4'd10,
        PH_FADE_C = 4'd11,
        PH_FADE_H = 4'd12,
        PH_FADE_L = 4'd13
    } phase_t;

    typedef enum logic [3:0] {
        EV_LOOP_HDR = 4'd0,
        EV_LOOP_ID  = 4'd1,
        EV_SET_HDR  = 4'd2,
        EV_SET_ID   = 4'd3,
        EV_FADE_IN  = 4'd4,
        EV_FADE_OUT = 4'd5,
        EV_COMPLETE = 4'd6,
        EV_TRUNC    = 4'd7,
        EV_UNKNOWN  = 4'd8
    } event_kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        event_kind_t event_kind;
        logic [15:0] item_id;
        logic [7:0]  item_count;
        logic [3:0]  set_slot;
        logic        accepted;
        logic [20:0] min_ms;
        logic [20:0] max_ms;
        logic [7:0]  fade_curve;
        logic [20:0] fade_ms;
        logic [15:0] consumed_bytes;
        logic        last_result;
    } out_word_t;

    // Up to two result words produced by one input word.
    typedef struct packed {
        logic [1:0] count;
        out_word_t  res0;
        out_word_t  res1;
    } res_push_t;

    // Ticks to milliseconds: times 20 as (x << 4) + (x << 2).
    function automatic logic [20:0] ticks_to_ms(input logic [15:0] ticks);
        logic [20:0] wide;
        wide = {5'd0, ticks};
        return (wide << 4) + (wide << 2);
    endfunction

endpackage

// File: src/ord_parser.sv
// Parse state and event generation for one input word per cycle while step is high.
// Depends on ord_pkg.
module ord_parser
    import ord_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step,
    input  in_word_t  in_word,
    output res_push_t push
);

    phase_t      phase_reg,   phase_next;
    logic        halted_reg,  halted_next;
    logic [15:0] pos_reg,     pos_next;
    logic [7:0]  ids_reg,     ids_next;
    logic [7:0]  hi_reg,      hi_next;
    logic [15:0] min_reg,     min_next;
    logic [15:0] max_reg,     max_next;
    logic [7:0]  curve_reg,   curve_next;
    logic [3:0]  kept_reg,    kept_next;
    logic        kflag_reg,   kflag_next;
    logic        loop_reg,    loop_next;
    logic [7:0]  dropped_reg, dropped_next;
    logic [15:0] super_reg,   super_next;

    // Next state and result words for the word in the input register.
    always_comb begin
        phase_t      c_phase;
        logic        c_halted;
        logic [15:0] c_pos;
        logic [7:0]  c_ids;
        logic [7:0]  c_hi;
        logic [15:0] c_min;
        logic [15:0] c_max;
        logic [7:0]  c_curve;
        logic [3:0]  c_kept;
        logic        c_kflag;
        logic        c_loop;
        logic [7:0]  c_dropped;
        logic [15:0] c_super;
        logic [7:0]  b;
        logic [15:0] word;
        logic [3:0]  slot;
        logic        has_ev;
        logic        has_trunc;
        out_word_t   ev;
        out_word_t   trunc;

        // A first word starts from the reset state.
        if (in_word.first_byte) begin
            c_phase = PH_OPCODE; c_halted = 1'b0; c_pos = '0; c_ids = '0;
            c_hi = '0; c_min = '0; c_max = '0; c_curve = '0; c_kept = '0;
            c_kflag = 1'b0; c_loop = 1'b0; c_dropped = '0; c_super = '0;
        end else begin
            c_phase = phase_reg; c_halted = halted_reg; c_pos = pos_reg;
            c_ids = ids_reg; c_hi = hi_reg; c_min = min_reg; c_max = max_reg;
            c_curve = curve_reg; c_kept = kept_reg; c_kflag = kflag_reg;
            c_loop = loop_reg; c_dropped = dropped_reg; c_super = super_reg;
        end

        phase_next = c_phase; halted_next = c_halted; pos_next = c_pos;
        ids_next = c_ids; hi_next = c_hi; min_next = c_min; max_next = c_max;
        curve_next = c_curve; kept_next = c_kept; kflag_next = c_kflag;
        loop_next = c_loop; dropped_next = c_dropped; super_next = c_super;

        b         = in_word.data_byte;
        word      = {c_hi, b};
        slot      = '0;
        has_ev    = 1'b0;
        has_trunc = 1'b0;
        ev        = '0;
        trunc     = '0;
        trunc.event_kind = EV_TRUNC;

        if (!c_halted) begin
            pos_next = (c_pos != 16'hFFFF) ? c_pos + 16'd1 : c_pos;

            case (c_phase)
                PH_OPCODE: begin
                    if (b == OP_END) begin
                        has_ev            = 1'b1;
                        ev.event_kind     = EV_COMPLETE;
                        ev.item_id        = c_super;
                        ev.item_count     = c_dropped;
                        ev.set_slot       = c_kept;
                        ev.consumed_bytes = pos_next;
                        halted_next       = 1'b1;
                    end else if (b == OP_LOOP) begin
                        phase_next = PH_LOOP_N;
                    end else if (b == OP_SET) begin
                        phase_next = PH_MIN_H;
                    end else if (b == OP_FIN || b == OP_FOUT) begin
                        ids_next   = (b == OP_FOUT) ? 8'd1 : 8'd0;
                        phase_next = PH_FADE_C;
                    end else begin
                        has_ev        = 1'b1;
                        ev.event_kind = EV_UNKNOWN;
                        ev.item_id    = {8'd0, b};
                        halted_next   = 1'b1;
                    end
                end
                PH_LOOP_N: begin
                    if (c_loop && c_super != 16'hFFFF) begin
                        super_next = c_super + 16'd1;
                    end
                    loop_next     = (b != 8'd0);
                    has_ev        = 1'b1;
                    ev.event_kind = EV_LOOP_HDR;
                    ev.item_count = b;
                    ids_next      = b;
                    phase_next    = (b == 8'd0) ? PH_OPCODE : PH_LOOP_H;
                end
                PH_LOOP_H, PH_MIN_H, PH_MAX_H, PH_SID_H, PH_FADE_H: begin
                    hi_next    = b;
                    phase_next = phase_t'(c_phase + 4'd1);
                end
                PH_LOOP_L: begin
                    has_ev        = 1'b1;
                    ev.event_kind = EV_LOOP_ID;
                    ev.item_id    = word;
                    ids_next      = c_ids - 8'd1;
                    phase_next    = (ids_next == 8'd0) ? PH_OPCODE : PH_LOOP_H;
                end
                PH_MIN_L: begin
                    min_next   = word;
                    phase_next = PH_MAX_H;
                end
                PH_MAX_L: begin
                    max_next   = word;
                    phase_next = PH_SET_N;
                end
                PH_SET_N: begin
                    if (b <= MAX_SET_IDS && c_kept < MAX_SETS) begin
                        kept_next  = c_kept + 4'd1;
                        kflag_next = 1'b1;
                    end else begin
                        kflag_next = 1'b0;
                        if (c_dropped != 8'hFF) begin
                            dropped_next = c_dropped + 8'd1;
                        end
                    end
                    slot          = kflag_next ? kept_next - 4'd1 : 4'd0;
                    has_ev        = 1'b1;
                    ev.event_kind = EV_SET_HDR;
                    ev.item_count = b;
                    ev.set_slot   = slot;
                    ev.accepted   = kflag_next;
                    ev.min_ms     = ticks_to_ms(c_min);
                    ev.max_ms     = ticks_to_ms(c_max);
                    ids_next      = b;
                    phase_next    = (b == 8'd0) ? PH_OPCODE : PH_SID_H;
                end
                PH_SID_L: begin
                    slot          = c_kflag ? c_kept - 4'd1 : 4'd0;
                    has_ev        = 1'b1;
                    ev.event_kind = EV_SET_ID;
                    ev.item_id    = word;
                    ev.set_slot   = slot;
                    ev.accepted   = c_kflag;
                    ids_next      = c_ids - 8'd1;
                    phase_next    = (ids_next == 8'd0) ? PH_OPCODE : PH_SID_H;
                end
                PH_FADE_C: begin
                    curve_next = b;
                    phase_next = PH_FADE_H;
                end
                PH_FADE_L: begin
                    has_ev        = 1'b1;
                    ev.event_kind = (c_ids != 8'd0) ? EV_FADE_OUT : EV_FADE_IN;
                    ev.fade_curve = c_curve;
                    ev.fade_ms    = ticks_to_ms(word);
                    ids_next      = '0;
                    phase_next    = PH_OPCODE;
                end
                default: begin
                    phase_next = PH_OPCODE;
                end
            endcase

            // End of buffer without a finished record.
            if (in_word.last_byte && !halted_next) begin
                has_trunc   = 1'b1;
                halted_next = 1'b1;
            end
        end

        // Pack the results in order and mark the last one.
        push = '0;
        if (has_ev) begin
            push.res0             = ev;
            push.res0.last_result = !has_trunc;
            push.res1             = trunc;
            push.res1.last_result = 1'b1;
            push.count            = has_trunc ? 2'd2 : 2'd1;
        end else if (has_trunc) begin
            push.res0             = trunc;
            push.res0.last_result = 1'b1;
            push.count            = 2'd1;
        end
    end

    // State registers advance once per consumed input word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_OPCODE; halted_reg <= 1'b0; pos_reg <= '0;
            ids_reg <= '0; hi_reg <= '0; min_reg <= '0; max_reg <= '0;
            curve_reg <= '0; kept_reg <= '0; kflag_reg <= 1'b0;
            loop_reg <= 1'b0; dropped_reg <= '0; super_reg <= '0;
        end else if (step) begin
            phase_reg <= phase_next; halted_reg <= halted_next; pos_reg <= pos_next;
            ids_reg <= ids_next; hi_reg <= hi_next; min_reg <= min_next;
            max_reg <= max_next; curve_reg <= curve_next; kept_reg <= kept_next;
            kflag_reg <= kflag_next; loop_reg <= loop_next;
            dropped_reg <= dropped_next; super_reg <= super_next;
        end
    end

endmodule

// File: src/ord_res_queue.sv
// Small result queue that takes up to two result words per cycle and hands out one.
// Depends on ord_pkg.
module ord_res_queue
    import ord_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  res_push_t         push,
    output logic [QCNT_W-1:0] fill,
    output logic              m_valid,
    input  logic              m_ready,
    output out_word_t         m_data
);

    out_word_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              pop;

    assign fill    = cnt_reg;
    assign m_valid = (cnt_reg != '0);
    assign m_data  = entry_reg[rd_reg];
    assign pop     = m_valid && m_ready;

    // Pointer and fill count update.
    always_comb begin
        wr_next  = wr_reg + QPTR_W'(push.count);
        rd_next  = rd_reg + QPTR_W'(pop);
        cnt_next = cnt_reg + QCNT_W'(push.count) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Result words are written in order at the write pointer.
    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entry_reg[wr_reg] <= push.res0;
        end
        if (push.count == 2'd2) begin
            entry_reg[wr_reg + QPTR_W'(1)] <= push.res1;
        end
    end

endmodule

// File: src/opcode_record_decoder.sv
// Top level of the opcode record decoder: input register, parser and result queue.
// Depends on ord_pkg, ord_parser and ord_res_queue.
//
//   Channel  Direction  Handshake            Word
//   s_       in         s_valid / s_ready    in_word_t: data_byte, first_byte, last_byte
//   m_       out        m_valid / m_ready    out_word_t: one decoded event
//
// One input word is taken per cycle while s_ready is high; it is parsed out of the input
// register and its zero to two events land in a four-entry result queue.
// An event is offered on m_ once its input word has passed the input register and the queue.
// The input register advances only while the queue has room for two events, so a stall
// on m_ backs up to s_ready after the queue and input register fill.
// Reset is synchronous on aresetn low and clears the parse state and the queue.
module opcode_record_decoder
    import ord_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    logic              in_valid_reg;
    in_word_t          in_data_reg;
    logic              step;
    logic [QCNT_W-1:0] fill;
    res_push_t         parsed;
    res_push_t         push;

    // Parse the held word when the queue can take two more events.
    assign step    = in_valid_reg && (fill <= QCNT_W'(QUEUE_DEPTH - 2));
    assign s_ready = !in_valid_reg || step;

    always_comb begin
        push = parsed;
        if (!step) begin
            push.count = 2'd0;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    ord_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .in_word (in_data_reg),
        .push    (parsed)
    );

    ord_res_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .fill    (fill),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: src/ord_checker.sv
// Port-level checks for the opcode record decoder, bound to the top level.
// Depends on ord_pkg and opcode_record_decoder.
module ord_checker
    import ord_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_word_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    // A waiting input word stays offered with the same payload.
    a_s_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input word withdrawn or changed while waiting");

    // A stalled result word stays offered.
    a_m_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word withdrawn while stalled");

    // A stalled result word keeps its payload.
    a_m_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result word changed while stalled");

    // Events that halt the parse are always the last result of their input word.
    a_halt_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.event_kind == EV_COMPLETE || m_data.event_kind == EV_TRUNC ||
                    m_data.event_kind == EV_UNKNOWN) |-> m_data.last_result)
        else $error("halting event not marked last");

    // A dropped set never shows a slot.
    a_drop_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.event_kind == EV_SET_HDR || m_data.event_kind == EV_SET_ID) &&
        !m_data.accepted |-> m_data.set_slot == 4'd0)
        else $error("dropped set carries a slot");

endmodule

bind opcode_record_decoder ord_checker u_ord_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
